// ===== src/pal_pkg.sv =====
// shared types and constants of the positional array list
package pal_pkg;

  // fixed field widths of the stream payloads
  localparam int FUNC_W      = 2;
  localparam int POS_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int RDATA_W     = 32;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RDATA_W - COUNT_W;

  // modulo unit: magnitude bits retired per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = POS_W / MOD_BITS;

  // cells per group in the read gather tree
  localparam int GROUP_SIZE = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_EXEC   = 3'd1,
    S_MOD    = 3'd2,
    S_SEL    = 3'd3,
    S_GATHER = 3'd4,
    S_RESULT = 3'd5
  } state_e;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] mag;
  } mod_req_t;

endpackage

// ===== src/positional_array_list.sv =====
// top level of the positional array list
//
// an ordered list of up to DEPTH words held in a row of cells. each input
// transfer carries one operation in tuser: insert at a position from 0 to
// count (later entries move up one cell), remove at a position from 0 to
// count-1 (later entries move down one cell), or read at a signed index that
// wraps modulo the count, a negative remainder lifted by the count. every
// input transfer gives exactly one output transfer with a status, the read
// word (zero unless a read succeeded) and the count after the operation.
// insert into a full list reports full, a position outside the list or an
// unused operation code reports out of range, a read from an empty list
// reports empty. cells shift all at once, so insert and remove pass through
// accept, cell update and result. a read passes through accept, request
// decode, the remainder unit at 4 bits a cycle over the 16-bit index, a step
// that folds the sign, then a select and a gather step that read the
// addressed cell through a registered or-tree over groups of 32 cells, then
// the result step. one operation is in flight at a time; the output
// register lets the next transfer be accepted while a result still waits
// downstream. cell contents are not cleared by reset and only cells below
// the count are read.
module positional_array_list #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: position [15:0], value [47:16]
  input  logic [pal_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [pal_pkg::FUNC_W-1:0]         s_axis_tuser_i,
  // master side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: read_data [31:0], count [36:32], zero pad [39:37]
  output logic [pal_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // tuser: status [1:0]
  output logic [pal_pkg::STATUS_W-1:0]       m_axis_tuser_o
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IW     = $clog2(DEPTH);
  localparam int GROUPS = (DEPTH + pal_pkg::GROUP_SIZE - 1) / pal_pkg::GROUP_SIZE;
  localparam int CMPW   = pal_pkg::POS_W;

  // control state
  pal_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  // latched request
  pal_pkg::func_e                 func_q;
  logic [pal_pkg::POS_W-1:0]      pos_q;
  logic [pal_pkg::VALUE_W-1:0]    val_q;

  // result staging and output register
  pal_pkg::status_e               res_status_q, res_status_d;
  logic [pal_pkg::RDATA_W-1:0]    res_data_q, res_data_d;
  logic [IW-1:0]                  idx_q, idx_d;
  logic                           grp_ld;
  logic                           out_ld;
  logic                           m_valid_q;
  logic [pal_pkg::STATUS_W-1:0]   out_status_q;
  logic [pal_pkg::RDATA_W-1:0]    out_data_q;
  logic [pal_pkg::COUNT_W-1:0]    out_count_q;

  // position checks
  logic            pos_neg;
  logic [CMPW-1:0] pos_u;
  logic [CMPW-1:0] cnt_ext;
  logic            ins_ok, rem_ok, full;
  logic            ins_go, rem_go;

  // remainder unit
  pal_pkg::mod_req_t mod_req;
  logic              mod_done;
  logic [CW-1:0]     mod_rem;
  logic [CW-1:0]     wrap_idx;

  // cell row
  pal_pkg::cell_op_e     cell_op [DEPTH];
  logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd [DEPTH];
  logic [DATA_WIDTH-1:0] grp_q   [GROUPS];
  logic [DATA_WIDTH-1:0] grp_d   [GROUPS];
  logic [DATA_WIDTH-1:0] grp_or;

  assign s_axis_tready_o = (state_q == pal_pkg::S_IDLE);

  assign pos_neg = pos_q[pal_pkg::POS_W-1];
  assign pos_u   = {1'b0, pos_q[pal_pkg::POS_W-2:0]};
  assign cnt_ext = CMPW'(cnt_q);
  assign ins_ok  = !pos_neg && (pos_u <= cnt_ext);
  assign rem_ok  = !pos_neg && (pos_u < cnt_ext);
  assign full    = (cnt_q == CW'(DEPTH));

  assign ins_go = (state_q == pal_pkg::S_EXEC) && (func_q == pal_pkg::FUNC_INSERT)
                  && ins_ok && !full;
  assign rem_go = (state_q == pal_pkg::S_EXEC) && (func_q == pal_pkg::FUNC_REMOVE)
                  && rem_ok;

  // negative index with a nonzero remainder lands count - remainder
  assign wrap_idx = (pos_neg && (mod_rem != '0)) ? (cnt_q - mod_rem) : mod_rem;

  // accept latch
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      func_q <= pal_pkg::func_e'(s_axis_tuser_i);
      pos_q  <= s_axis_tdata_i[pal_pkg::POS_W-1:0];
      val_q  <= s_axis_tdata_i[pal_pkg::POS_W +: pal_pkg::VALUE_W];
    end
  end

  // state and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pal_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and sequencing
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    idx_d        = idx_q;
    grp_ld       = 1'b0;
    out_ld       = 1'b0;
    mod_req      = '0;
    mod_req.mag  = pos_neg ? (~pos_q + 1'b1) : pos_q;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = pal_pkg::S_EXEC;
        end
      end
      pal_pkg::S_EXEC: begin
        res_data_d = '0;
        state_d    = pal_pkg::S_RESULT;
        unique case (func_q)
          pal_pkg::FUNC_INSERT: begin
            priority if (!ins_ok) begin
              res_status_d = pal_pkg::ST_RANGE;
            end else if (full) begin
              res_status_d = pal_pkg::ST_FULL;
            end else begin
              res_status_d = pal_pkg::ST_OK;
              cnt_d        = cnt_q + 1'b1;
            end
          end
          pal_pkg::FUNC_REMOVE: begin
            if (rem_ok) begin
              res_status_d = pal_pkg::ST_OK;
              cnt_d        = cnt_q - 1'b1;
            end else begin
              res_status_d = pal_pkg::ST_RANGE;
            end
          end
          pal_pkg::FUNC_READ: begin
            if (cnt_q == '0) begin
              res_status_d = pal_pkg::ST_EMPTY;
            end else begin
              res_status_d  = pal_pkg::ST_OK;
              mod_req.start = 1'b1;
              state_d       = pal_pkg::S_MOD;
            end
          end
          default: begin
            res_status_d = pal_pkg::ST_RANGE;
          end
        endcase
      end
      pal_pkg::S_MOD: begin
        if (mod_done) begin
          idx_d   = IW'(wrap_idx);
          state_d = pal_pkg::S_SEL;
        end
      end
      pal_pkg::S_SEL: begin
        grp_ld  = 1'b1;
        state_d = pal_pkg::S_GATHER;
      end
      pal_pkg::S_GATHER: begin
        res_data_d = pal_pkg::RDATA_W'(grp_or);
        state_d    = pal_pkg::S_RESULT;
      end
      pal_pkg::S_RESULT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_ld  = 1'b1;
          state_d = pal_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    idx_q        <= idx_d;
  end

  // per-cell shift command: insert moves cells above the position up,
  // remove pulls cells from the position on down
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = pal_pkg::CELL_HOLD;
      if (ins_go) begin
        if (CMPW'(i) == pos_u) begin
          cell_op[i] = pal_pkg::CELL_LOAD;
        end else if ((CMPW'(i) > pos_u) && (CMPW'(i) <= cnt_ext)) begin
          cell_op[i] = pal_pkg::CELL_FROM_LOWER;
        end
      end else if (rem_go) begin
        if ((CMPW'(i) >= pos_u) && ((CMPW'(i) + 1'b1) < cnt_ext)) begin
          cell_op[i] = pal_pkg::CELL_FROM_UPPER;
        end
      end
    end
  end

  // the row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_w, upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = cell_q[i+1];
    end
    pal_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .load_i  (DATA_WIDTH'(val_q)),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .hit_i   (idx_q == IW'(i)),
      .q_o     (cell_q[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // first gather level: or of each group of cells
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < pal_pkg::GROUP_SIZE; j++) begin
        if (g * pal_pkg::GROUP_SIZE + j < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_rd[g * pal_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_ld) begin
      grp_q <= grp_d;
    end
  end

  // second gather level
  always_comb begin
    grp_or = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_or = grp_or | grp_q[g];
    end
  end

  pal_mod #(
    .CW (CW)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .div_i  (cnt_q),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_count_q  <= pal_pkg::COUNT_W'(cnt_q);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{pal_pkg::OUT_PAD_W{1'b0}}, out_count_q, out_data_q};

`ifndef SYNTH
  // count never runs past the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // count only moves as the cell update is applied
  a_cnt_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == pal_pkg::S_EXEC))
    else $error("entry count changed outside the update cycle");

  // a remainder only arrives while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == pal_pkg::S_MOD))
    else $error("remainder finished with no read waiting");

  // an empty report always goes out with a zero count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_status_q == pal_pkg::ST_EMPTY)) |-> (out_count_q == '0))
    else $error("empty status with nonzero count");
`endif

endmodule

// ===== src/pal_cell.sv =====
// one storage cell of the list: holds an entry and trades it with its neighbors
module pal_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  pal_pkg::cell_op_e      op_i,
  input  logic [DATA_WIDTH-1:0]  load_i,
  input  logic [DATA_WIDTH-1:0]  lower_i,
  input  logic [DATA_WIDTH-1:0]  upper_i,
  input  logic                   hit_i,
  output logic [DATA_WIDTH-1:0]  q_o,
  output logic [DATA_WIDTH-1:0]  rd_o
);

  logic [DATA_WIDTH-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      pal_pkg::CELL_HOLD:       entry_q <= entry_q;
      pal_pkg::CELL_LOAD:       entry_q <= load_i;
      pal_pkg::CELL_FROM_LOWER: entry_q <= lower_i;
      pal_pkg::CELL_FROM_UPPER: entry_q <= upper_i;
    endcase
  end

  assign q_o  = entry_q;
  // masked so the gather tree can simply or the cells together
  assign rd_o = hit_i ? entry_q : '0;

endmodule

// ===== src/pal_mod.sv =====
// iterative remainder unit, MOD_BITS restoring subtract steps per cycle
module pal_mod #(
  parameter int CW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pal_pkg::mod_req_t   req_i,
  input  logic [CW-1:0]       div_i,
  output logic                done_o,
  output logic [CW-1:0]       rem_o
);

  localparam int STEP_W = (pal_pkg::MOD_STEPS > 1) ? $clog2(pal_pkg::MOD_STEPS) : 1;

  logic                      busy_q;
  logic                      done_q;
  logic [STEP_W-1:0]         step_q;
  logic [pal_pkg::POS_W-1:0] dvd_q, dvd_v;
  logic [CW:0]               rem_q, rem_v;

  always_comb begin
    rem_v = rem_q;
    dvd_v = dvd_q;
    for (int k = 0; k < pal_pkg::MOD_BITS; k++) begin
      rem_v = {rem_v[CW-1:0], dvd_v[pal_pkg::POS_W-1]};
      dvd_v = {dvd_v[pal_pkg::POS_W-2:0], 1'b0};
      if (rem_v >= {1'b0, div_i}) begin
        rem_v = rem_v - {1'b0, div_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(pal_pkg::MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.mag;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_v;
      rem_q <= rem_v;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[CW-1:0];

endmodule
